FILE: hw/rtl/tsra_pkg.sv
// Shared constants, types and state encoding for the sensor resistance averager.
package tsra_pkg;

  localparam int     ADC_FULL_SCALE = 4096;
  localparam int     ADC_BITS       = 12;
  localparam longint MILLI_SCALE    = 1000;
  localparam longint RES_SCALE      = longint'(ADC_FULL_SCALE) * MILLI_SCALE;

  localparam int TIME_W = 32;
  localparam int RES_W  = 32;
  localparam int SUM_W  = 40;
  localparam int CNT_W  = 8;
  localparam int LOAD_W = 8;

  localparam int NUM_W      = $clog2(RES_SCALE * ((longint'(1) << LOAD_W) - 1) + 1);
  localparam int DVD_RAW_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DVD_W      = ((DVD_RAW_W + 1) / 2) * 2;
  localparam int DVS_W      = (ADC_BITS > CNT_W) ? ADC_BITS : CNT_W;
  localparam int DIV_CYCLES = DVD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [RES_W-1:0] RES_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOAD     = 2'd2;

  localparam logic [TIME_W-1:0] INTERVAL_RST = '0;
  localparam logic [CNT_W-1:0]  TARGET_RST   = 8'd1;
  localparam logic [LOAD_W-1:0] LOAD_RST     = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RES_DIV,
    ST_MEAN_START,
    ST_MEAN_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] interval_ms;
    logic [CNT_W-1:0]  sample_target;
    logic [LOAD_W-1:0] load_resistance;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic clear_run;
    logic skip;
    logic res_div_start;
    logic res_commit;
    logic mean_div_start;
    logic mean_commit;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic take;
    logic fault;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/tsra_in_if.sv
// Input channel carrying start commands and timestamped converter samples.
interface tsra_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tsra_pkg::TIME_W-1:0]   time_ms;
  logic [tsra_pkg::ADC_BITS-1:0] raw_adc;

  modport source (output valid, output func, output time_ms, output raw_adc, input ready);
  modport sink (input valid, input func, input time_ms, input raw_adc, output ready);
endinterface

FILE: hw/rtl/tsra_out_if.sv
// Output channel carrying one result per input transaction.
interface tsra_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [tsra_pkg::RES_W-1:0] resistance;
  logic [tsra_pkg::RES_W-1:0] average;
  logic [tsra_pkg::CNT_W-1:0] sample_count;
  logic                       complete;
  logic                       fault;

  modport source (output valid, output accepted, output resistance, output average,
                  output sample_count, output complete, output fault, input ready);
  modport sink (input valid, input accepted, input resistance, input average,
                input sample_count, input complete, input fault, output ready);
endinterface

FILE: hw/rtl/tsra_regs.sv
// APB configuration registers: interval, sample target and load resistance.
module tsra_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [tsra_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [tsra_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [tsra_pkg::PDATA_W-1:0]   prdata_o,
  output logic                           pready_o,
  output tsra_pkg::cfg_t                 cfg_o
);

  tsra_pkg::cfg_t                      cfg_q;
  logic [tsra_pkg::REG_IDX_W-1:0]      idx;
  logic                                wr_en;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[tsra_pkg::PADDR_W-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms     <= tsra_pkg::INTERVAL_RST;
      cfg_q.sample_target   <= tsra_pkg::TARGET_RST;
      cfg_q.load_resistance <= tsra_pkg::LOAD_RST;
    end else if (wr_en) begin
      case (idx)
        tsra_pkg::REG_INTERVAL: cfg_q.interval_ms     <= pwdata_i[tsra_pkg::TIME_W-1:0];
        tsra_pkg::REG_TARGET:   cfg_q.sample_target   <= pwdata_i[tsra_pkg::CNT_W-1:0];
        tsra_pkg::REG_LOAD:     cfg_q.load_resistance <= pwdata_i[tsra_pkg::LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tsra_pkg::REG_INTERVAL: prdata_o = tsra_pkg::PDATA_W'(cfg_q.interval_ms);
      tsra_pkg::REG_TARGET:   prdata_o = tsra_pkg::PDATA_W'(cfg_q.sample_target);
      tsra_pkg::REG_LOAD:     prdata_o = tsra_pkg::PDATA_W'(cfg_q.load_resistance);
      default:                prdata_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tsra_div.sv
// Shared restoring divider that retires two quotient bits per cycle.
module tsra_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsra_pkg::DVD_W-1:0]   dividend_i,
  input  logic [tsra_pkg::DVS_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [tsra_pkg::DVD_W-1:0]   quotient_o
);

  localparam int DVD_W = tsra_pkg::DVD_W;
  localparam int DVS_W = tsra_pkg::DVS_W;

  logic [DVS_W-1:0]               rem_q;
  logic [DVD_W-1:0]               quo_q;
  logic [DVS_W-1:0]               dvs_q;
  logic [tsra_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [DVS_W:0]                 r1;
  logic [DVS_W:0]                 r2;
  logic [DVD_W-1:0]               q1;
  logic [DVD_W-1:0]               q2;
  logic                           ge1;
  logic                           ge2;

  always_comb begin
    r1  = {rem_q, quo_q[DVD_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    if (ge1) begin
      r1 = r1 - {1'b0, dvs_q};
    end
    q1  = {quo_q[DVD_W-2:0], ge1};
    r2  = {r1[DVS_W-1:0], q1[DVD_W-1]};
    ge2 = (r2 >= {1'b0, dvs_q});
    if (ge2) begin
      r2 = r2 - {1'b0, dvs_q};
    end
    q2  = {q1[DVD_W-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tsra_pkg::DIV_CNT_W'(tsra_pkg::DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= r2[DVS_W-1:0];
      quo_q <= q2;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/tsra_dp.sv
// Datapath: run state, sample qualification, resistance and average division, result register.
module tsra_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsra_pkg::cmd_t                 cmd_i,
  input  tsra_pkg::cfg_t                 cfg_i,
  input  logic                           in_func_i,
  input  logic [tsra_pkg::TIME_W-1:0]    in_time_i,
  input  logic [tsra_pkg::ADC_BITS-1:0]  in_raw_i,
  input  logic                           out_ready_i,
  output tsra_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  output logic                           out_accepted_o,
  output logic [tsra_pkg::RES_W-1:0]     out_resistance_o,
  output logic [tsra_pkg::RES_W-1:0]     out_average_o,
  output logic [tsra_pkg::CNT_W-1:0]     out_count_o,
  output logic                           out_complete_o,
  output logic                           out_fault_o
);

  localparam int DVD_W = tsra_pkg::DVD_W;
  localparam int NUM_W = tsra_pkg::NUM_W;
  localparam int ADC_BITS = tsra_pkg::ADC_BITS;

  logic                           in_func_q;
  logic [tsra_pkg::TIME_W-1:0]    in_time_q;
  logic [ADC_BITS-1:0]            in_raw_q;

  logic [tsra_pkg::TIME_W-1:0]    last_time_q;
  logic [tsra_pkg::SUM_W-1:0]     sum_q;
  logic [tsra_pkg::CNT_W-1:0]     count_q;
  logic [tsra_pkg::RES_W-1:0]     mean_q;
  logic                           done_q;

  logic                           res_acc_q;
  logic [tsra_pkg::RES_W-1:0]     res_val_q;
  logic                           res_flt_q;

  logic                           out_valid_q;
  logic                           out_acc_q;
  logic [tsra_pkg::RES_W-1:0]     out_res_q;
  logic [tsra_pkg::RES_W-1:0]     out_avg_q;
  logic [tsra_pkg::CNT_W-1:0]     out_cnt_q;
  logic                           out_cmp_q;
  logic                           out_flt_q;

  logic [tsra_pkg::TIME_W-1:0]    elapsed;
  logic                           considered;
  logic                           raw_above;
  logic [ADC_BITS-1:0]            den;
  logic [NUM_W-1:0]               num;
  logic                           div_start;
  logic [DVD_W-1:0]               div_dividend;
  logic [tsra_pkg::DVS_W-1:0]     div_divisor;
  logic [DVD_W-1:0]               div_quo;
  logic                           div_busy;
  logic                           div_done;
  logic [tsra_pkg::RES_W-1:0]     res_sat;
  logic [tsra_pkg::CNT_W-1:0]     cnt_inc;

  assign elapsed    = in_time_q - last_time_q;
  assign considered = in_func_q & ~done_q & (elapsed > cfg_i.interval_ms);
  assign raw_above  = in_raw_q > ADC_BITS'(cfg_i.load_resistance);
  assign den        = in_raw_q - ADC_BITS'(cfg_i.load_resistance);
  assign num        = NUM_W'(tsra_pkg::RES_SCALE) * NUM_W'(cfg_i.load_resistance);

  assign div_start    = cmd_i.res_div_start | cmd_i.mean_div_start;
  assign div_dividend = cmd_i.res_div_start ? DVD_W'(num) : DVD_W'(sum_q);
  assign div_divisor  = cmd_i.res_div_start ? tsra_pkg::DVS_W'(den)
                                            : tsra_pkg::DVS_W'(count_q);

  assign res_sat = (div_quo > DVD_W'(tsra_pkg::RES_MAX)) ? tsra_pkg::RES_MAX
                                                        : div_quo[tsra_pkg::RES_W-1:0];
  assign cnt_inc = (count_q == tsra_pkg::CNT_MAX) ? count_q : count_q + 1'b1;

  tsra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sts_o.is_start = ~in_func_q;
    sts_o.take     = considered & raw_above;
    sts_o.fault    = considered & ~raw_above;
    sts_o.div_busy = div_busy;
    sts_o.div_done = div_done;
    sts_o.out_free = ~out_valid_q | out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      mean_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_run) begin
        last_time_q <= in_time_q;
        sum_q       <= '0;
        count_q     <= '0;
        mean_q      <= '0;
        done_q      <= 1'b0;
      end
      if (cmd_i.res_commit) begin
        last_time_q <= in_time_q;
        sum_q       <= sum_q + tsra_pkg::SUM_W'(res_sat);
        count_q     <= cnt_inc;
        done_q      <= (cnt_inc >= cfg_i.sample_target);
      end
      if (cmd_i.mean_commit) begin
        mean_q <= div_quo[tsra_pkg::RES_W-1:0];
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_func_q <= in_func_i;
      in_time_q <= in_time_i;
      in_raw_q  <= in_raw_i;
    end
    if (cmd_i.clear_run || cmd_i.skip) begin
      res_acc_q <= 1'b0;
      res_val_q <= '0;
      res_flt_q <= cmd_i.skip & sts_o.fault;
    end
    if (cmd_i.res_commit) begin
      res_acc_q <= 1'b1;
      res_val_q <= res_sat;
      res_flt_q <= 1'b0;
    end
    if (cmd_i.push) begin
      out_acc_q <= res_acc_q;
      out_res_q <= res_val_q;
      out_avg_q <= mean_q;
      out_cnt_q <= count_q;
      out_cmp_q <= done_q;
      out_flt_q <= res_flt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = out_acc_q;
  assign out_resistance_o = out_res_q;
  assign out_average_o    = out_avg_q;
  assign out_count_o      = out_cnt_q;
  assign out_complete_o   = out_cmp_q;
  assign out_fault_o      = out_flt_q;

  a_commit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_commit |=> count_q != '0)
    else $error("count is zero after a sample was taken");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_acc_q) |-> (out_res_q == '0))
    else $error("rejected transaction carries a nonzero resistance");

endmodule

FILE: hw/rtl/tsra_ctrl.sv
// Controller state machine sequencing qualification, the two divisions and the result push.
module tsra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tsra_pkg::sts_t  sts_i,
  output tsra_pkg::cmd_t  cmd_o
);

  tsra_pkg::state_e state_q;
  tsra_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tsra_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = tsra_pkg::ST_DECIDE;
        end
      end
      tsra_pkg::ST_DECIDE: begin
        if (sts_i.is_start) begin
          cmd_o.clear_run = 1'b1;
          state_d         = tsra_pkg::ST_PUSH;
        end else if (sts_i.take) begin
          cmd_o.res_div_start = 1'b1;
          state_d             = tsra_pkg::ST_RES_DIV;
        end else begin
          cmd_o.skip = 1'b1;
          state_d    = tsra_pkg::ST_PUSH;
        end
      end
      tsra_pkg::ST_RES_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_commit = 1'b1;
          state_d          = tsra_pkg::ST_MEAN_START;
        end
      end
      tsra_pkg::ST_MEAN_START: begin
        cmd_o.mean_div_start = 1'b1;
        state_d              = tsra_pkg::ST_MEAN_DIV;
      end
      tsra_pkg::ST_MEAN_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mean_commit = 1'b1;
          state_d           = tsra_pkg::ST_PUSH;
        end
      end
      tsra_pkg::ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = tsra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsra_pkg::ST_IDLE;
      end
    endcase
  end

  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> (state_q == tsra_pkg::ST_RES_DIV || state_q == tsra_pkg::ST_MEAN_DIV))
    else $error("divider running outside a division state");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == tsra_pkg::ST_RES_DIV || state_q == tsra_pkg::ST_MEAN_DIV))
    else $error("divider finished outside a division state");

  a_single_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_div_start || cmd_o.mean_div_start) |-> !sts_i.div_busy)
    else $error("division started while the divider is busy");

endmodule

FILE: hw/rtl/timed_sensor_resistance_averager_top.sv
// Top level of the timed sensor resistance averager.
// A start command or a rejected sample goes from the decide state straight to the push state.
// A taken sample makes two passes of the shared radix-4 divider, for the resistance and then the mean.
// One transaction is processed at a time; the next is accepted while a result waits.
// Reset clears the run state and the output valid and loads the register defaults.
module timed_sensor_resistance_averager_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsra_in_if.sink                       in_i,
  tsra_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsra_pkg::PADDR_W-1:0]  paddr,
  input  logic [tsra_pkg::PDATA_W-1:0]  pwdata,
  output logic [tsra_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  tsra_pkg::cfg_t cfg;
  tsra_pkg::cmd_t cmd;
  tsra_pkg::sts_t sts;

  tsra_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  tsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsra_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .in_func_i        (in_i.func),
    .in_time_i        (in_i.time_ms),
    .in_raw_i         (in_i.raw_adc),
    .out_ready_i      (out_o.ready),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_accepted_o   (out_o.accepted),
    .out_resistance_o (out_o.resistance),
    .out_average_o    (out_o.average),
    .out_count_o      (out_o.sample_count),
    .out_complete_o   (out_o.complete),
    .out_fault_o      (out_o.fault)
  );

endmodule

FILE: test/timed_sensor_resistance_averager_top_tb.sv
// Self-checking testbench for the timed sensor resistance averager with an in-bench run predictor.
module timed_sensor_resistance_averager_top_tb;
  import tsra_pkg::*;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct {
    cmd_e                  func;
    logic [TIME_W-1:0]     time_ms;
    logic [ADC_BITS-1:0]   raw_adc;
  } reading_t;

  typedef struct {
    logic              accepted;
    logic [RES_W-1:0]  resistance;
    logic [RES_W-1:0]  average;
    logic [CNT_W-1:0]  sample_count;
    logic              complete;
    logic              fault;
  } outcome_t;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 400;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                drv_valid = 1'b0;
  cmd_e                drv_func  = CMD_START;
  logic [TIME_W-1:0]   drv_time  = '0;
  logic [ADC_BITS-1:0] drv_raw   = '0;
  logic                mon_ready = 1'b0;
  reading_t            drv_next;

  tsra_in_if  in_if ();
  tsra_out_if out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.func    = drv_func;
  assign in_if.time_ms = drv_time;
  assign in_if.raw_adc = drv_raw;
  assign out_if.ready  = mon_ready;

  timed_sensor_resistance_averager_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [TIME_W-1:0] cfg_interval = INTERVAL_RST;
  logic [CNT_W-1:0]  cfg_target   = TARGET_RST;
  logic [LOAD_W-1:0] cfg_load     = LOAD_RST;

  logic [TIME_W-1:0] run_last_time = '0;
  logic [SUM_W-1:0]  run_sum       = '0;
  logic [CNT_W-1:0]  run_count     = '0;
  logic [RES_W-1:0]  run_mean      = '0;
  logic              run_done      = 1'b0;

  reading_t pending_readings[$];
  outcome_t expected_outcomes[$];

  int readings_sent    = 0;
  int outcomes_checked = 0;
  int samples_taken    = 0;
  int faults_seen      = 0;
  int runs_completed   = 0;
  int failures         = 0;
  int send_idle_pct    = 35;
  int recv_idle_pct    = 61;
  int recv_hold        = 0;
  int stall_cycles     = 0;
  logic [TIME_W-1:0] gen_time = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic outcome_t predict_outcome(input reading_t rd);
    outcome_t            o;
    logic [TIME_W-1:0]   elapsed;
    logic [ADC_BITS-1:0] span;
    logic [63:0]         quotient;
    o = '{default: '0};
    elapsed = rd.time_ms - run_last_time;
    if (rd.func == CMD_START) begin
      run_last_time = rd.time_ms;
      run_sum       = '0;
      run_count     = '0;
      run_mean      = '0;
      run_done      = 1'b0;
    end else if (!run_done && elapsed > cfg_interval) begin
      if (rd.raw_adc <= cfg_load) begin
        o.fault = 1'b1;
        faults_seen++;
      end else begin
        span     = rd.raw_adc - ADC_BITS'(cfg_load);
        quotient = (64'(ADC_FULL_SCALE) * 64'(MILLI_SCALE) * 64'(cfg_load)) / 64'(span);
        o.resistance = (quotient > 64'hFFFF_FFFF) ? RES_MAX : quotient[RES_W-1:0];
        o.accepted   = 1'b1;
        run_sum       = run_sum + SUM_W'(o.resistance);
        run_last_time = rd.time_ms;
        if (run_count != CNT_MAX) run_count++;
        run_mean = RES_W'(run_sum / SUM_W'(run_count));
        samples_taken++;
        if (run_count >= cfg_target) begin
          run_done = 1'b1;
          runs_completed++;
        end
      end
    end
    o.average      = run_mean;
    o.sample_count = run_count;
    o.complete     = run_done;
    return o;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic check_outcome();
    outcome_t want;
    if (expected_outcomes.size() == 0) begin
      $error("result transaction with no input transaction pending");
      failures++;
    end else begin
      want = expected_outcomes.pop_front();
      outcomes_checked++;
      compare_field("accepted", 32'(want.accepted), 32'(out_if.accepted));
      compare_field("resistance", want.resistance, out_if.resistance);
      compare_field("average", want.average, out_if.average);
      compare_field("sample_count", 32'(want.sample_count), 32'(out_if.sample_count));
      compare_field("complete", 32'(want.complete), 32'(out_if.complete));
      compare_field("fault", 32'(want.fault), 32'(out_if.fault));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        expected_outcomes.push_back(predict_outcome('{drv_func, drv_time, drv_raw}));
        readings_sent++;
      end
      if (!drv_valid || in_if.ready) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_next = pending_readings.pop_front();
          drv_valid <= 1'b1;
          drv_func  <= drv_next.func;
          drv_time  <= drv_next.time_ms;
          drv_raw   <= drv_next.raw_adc;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_if.valid && mon_ready) check_outcome();
      if (recv_hold > 0) begin
        recv_hold--;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (drv_valid && in_if.ready) || (out_if.valid && mon_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_reading(input cmd_e f, input logic [TIME_W-1:0] t,
                              input logic [ADC_BITS-1:0] r);
    pending_readings.push_back('{f, t, r});
  endtask

  // Sampled at the falling edge so that the driver's updates of the rising edge have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || drv_valid || expected_outcomes.size() != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INTERVAL: cfg_interval = value;
      REG_TARGET:   cfg_target   = value[CNT_W-1:0];
      REG_LOAD:     cfg_load     = value[LOAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_run(input int samples);
    int                  pick;
    logic [ADC_BITS-1:0] raw;
    gen_time = $urandom;
    push_reading(CMD_START, gen_time, ADC_BITS'($urandom));
    repeat (samples) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_reading(CMD_START, $urandom, ADC_BITS'($urandom));
      end else begin
        if (pick < 15) gen_time = gen_time + $urandom_range(0, cfg_interval);
        else gen_time = gen_time + cfg_interval + 32'd1 + $urandom_range(0, 40);
        pick = $urandom_range(99);
        if (pick < 10) raw = ADC_BITS'($urandom_range(0, cfg_load));
        else if (pick < 15) raw = ADC_BITS'(cfg_load) + 12'd1;
        else if (pick < 20) raw = '1;
        else raw = ADC_BITS'($urandom_range(cfg_load + 1, 4095));
        push_reading(CMD_SAMPLE, gen_time, raw);
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] interval, input int target, input int load,
                           input int items, input int lo, input int hi, input int hold);
    int queued;
    int len;
    queued = 0;
    wait_idle();
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_TARGET, target);
    write_reg(REG_LOAD, load);
    while (queued < items) begin
      len = $urandom_range(lo, hi);
      queue_run(len);
      queued += len + 1;
    end
    if (hold != 0) recv_hold = hold;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_reading(CMD_SAMPLE, 32'd0, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd5, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd9, 12'h000);

    wait_idle();
    write_reg(REG_INTERVAL, 32'd5);
    write_reg(REG_TARGET, 32'd3);
    write_reg(REG_LOAD, 32'd10);
    push_reading(CMD_START, 32'd1000, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd1003, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd1005, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd1006, 12'd10);
    push_reading(CMD_SAMPLE, 32'd1006, 12'd0);
    push_reading(CMD_SAMPLE, 32'd1006, 12'd11);
    push_reading(CMD_SAMPLE, 32'd1012, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd1018, 12'h800);
    push_reading(CMD_SAMPLE, 32'd1030, 12'hFFF);
    push_reading(CMD_START, 32'hFFFF_FFFC, 12'hFFF);
    push_reading(CMD_SAMPLE, 32'd2, 12'hAAA);
    push_reading(CMD_SAMPLE, 32'd8, 12'h555);
    push_reading(CMD_START, 32'hFFFF_FFFF, 12'h000);

    wait_idle();
    write_reg(REG_INTERVAL, 32'd0);
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_LOAD, 32'd255);
    push_reading(CMD_START, 32'hAAAA_AAAA, 12'h000);
    push_reading(CMD_SAMPLE, 32'hAAAA_AAAB, 12'd256);
    push_reading(CMD_SAMPLE, 32'h5555_5555, 12'hFFF);
    push_reading(CMD_START, 32'h5555_5555, 12'h000);
    push_reading(CMD_SAMPLE, 32'h5555_5555, 12'd300);
    push_reading(CMD_SAMPLE, 32'h5555_5556, 12'd255);
    push_reading(CMD_SAMPLE, 32'h5555_5557, 12'hFFF);

    run_phase(32'd100, 4, 10, 100, 1, 7, 0);
    run_phase(32'd0, 255, 1, 330, 330, 330, 0);

    send_idle_pct = 61;
    recv_idle_pct = 35;
    run_phase(32'hFFFF_FFFF, 1, 255, 12, 2, 5, 0);
    run_phase(32'hFFFF_FFF0, 2, 255, 40, 1, 4, 0);
    run_phase(32'd37, 8, 128, 150, 3, 12, LONG_HOLD);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(32'd1, 16, 200, 120, 5, 20, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      failures++;
    end
    $display("Sent %0d transactions and checked %0d results: %0d samples averaged, %0d faults,",
             readings_sent, outcomes_checked, samples_taken, faults_seen);
    $display("%0d runs completed across interval, target and load extremes and three idle mixes.",
             runs_completed);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
